### src/mixed_precision_dot_product_core_assert.svh
// Assertion macros for the dot-product core
`ifndef MIXED_PRECISION_DOT_PRODUCT_CORE_ASSERT_SVH
`define MIXED_PRECISION_DOT_PRODUCT_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define MPDP_ASSERT_IMPL(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MPDP_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MPDP_ASSERT_IMPL(label, prop, msg)
`define MPDP_ASSERT_RST(label, prop, msg)
`endif
`endif

### src/mpdp_pkg.sv
package mpdp_pkg;

  localparam logic [31:0] FP_POS_ZERO = 32'h0000_0000;
  localparam logic [31:0] FP_QNAN     = 32'h7FC0_0000;

  // controller to datapath
  typedef struct packed {
    logic load;   // capture request
    logic mul_a;  // product = weight * activation
    logic add_a;  // sum = acc + product
    logic mul_s;  // sum = sum * scale
    logic mul_b;  // product = beta * previous
    logic add_b;  // sum = sum + product
    logic commit; // write accumulator / clear on last
  } mpdp_cmd_t;

  typedef struct packed {
    logic last;
    logic op;
    logic beta_nz;
  } mpdp_sts_t;

  function automatic logic is_nan(input logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
  endfunction

  // leading-zero count over 48 bits
  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    logic       f;
    n = 6'd48;
    f = 1'b0;
    for (int i = 47; i >= 0; i--) begin
      if (!f && v[i]) begin
        n = 6'(47 - i);
        f = 1'b1;
      end
    end
    return n;
  endfunction

  // pack sign, unbiased-ish exponent (biased, signed) and normalised mantissa
  // m[47] is the leading one; round to nearest even
  function automatic logic [31:0] fp_round(input logic s, input logic signed [10:0] e,
                                           input logic [47:0] m);
    logic [49:0] sh;
    logic [23:0] mant;
    logic        g, st;
    logic [24:0] r;
    logic signed [10:0] ee;
    logic [10:0] amt;
    sh = {m, 2'b00};
    ee = e;
    if (e < 11'sd1) begin
      amt = 11'(11'sd1 - e);
      if (amt > 11'd49) sh = {49'd0, |m};
      else sh = (sh >> amt) | {49'd0, |(sh & ((50'd1 << amt) - 50'd1))};
      ee = 11'sd0;
    end
    mant = sh[49:26];
    g    = sh[25];
    st   = |sh[24:0];
    r    = {1'b0, mant} + {24'd0, g & (st | mant[0])};
    if (r[24]) begin
      r  = r >> 1;
      ee = ee + 11'sd1;
    end else if (ee == 11'sd0 && r[23]) begin
      ee = 11'sd1;
    end
    if (ee >= 11'sd255) return {s, 8'hFF, 23'd0};
    return {s, ee[7:0], r[22:0]};
  endfunction

  function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
    logic        s, ai, bi, az, bz;
    logic [23:0] ma, mb;
    logic [47:0] p;
    logic [5:0]  lz;
    logic signed [10:0] e;
    s  = a[31] ^ b[31];
    ai = a[30:23] == 8'hFF;
    bi = b[30:23] == 8'hFF;
    az = a[30:0] == 31'd0;
    bz = b[30:0] == 31'd0;
    if (is_nan(a) || is_nan(b) || (ai && bz) || (bi && az)) return FP_QNAN;
    if (ai || bi) return {s, 8'hFF, 23'd0};
    if (az || bz) return {s, 31'd0};
    ma = {a[30:23] != 8'd0, a[22:0]};
    mb = {b[30:23] != 8'd0, b[22:0]};
    p  = ma * mb;
    lz = lzc48(p);
    e  = 11'(a[30:23] == 8'd0 ? 1 : a[30:23]) + 11'(b[30:23] == 8'd0 ? 1 : b[30:23])
         - 11'sd126 - 11'(lz);
    p  = p << lz;
    return fp_round(s, e, p);
  endfunction

  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
    logic        ai, bi, sa, sb, sg;
    logic [31:0] x, y;
    logic [7:0]  ex, ey;
    logic [8:0]  d;
    logic [49:0] mx, my, mr;
    logic [5:0]  lz;
    logic signed [10:0] e;
    ai = a[30:23] == 8'hFF;
    bi = b[30:23] == 8'hFF;
    if (is_nan(a) || is_nan(b)) return FP_QNAN;
    if (ai && bi) return (a[31] == b[31]) ? a : FP_QNAN;
    if (ai) return a;
    if (bi) return b;
    if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return {a[31] & b[31], 31'd0};
    if (a[30:0] >= b[30:0]) begin x = a; y = b; end
    else begin x = b; y = a; end
    ex = x[30:23] == 8'd0 ? 8'd1 : x[30:23];
    ey = y[30:23] == 8'd0 ? 8'd1 : y[30:23];
    d  = {1'b0, ex} - {1'b0, ey};
    mx = {1'b0, x[30:23] != 8'd0, x[22:0], 25'd0};
    my = {1'b0, y[30:23] != 8'd0, y[22:0], 25'd0};
    if (d > 9'd48) my = {49'd0, |my};
    else my = (my >> d) | {49'd0, |(my & ((50'd1 << d) - 50'd1))};
    sa = x[31];
    sb = y[31];
    mr = (sa == sb) ? mx + my : mx - my;
    if (mr == 50'd0) return FP_POS_ZERO;
    sg = sa;
    lz = lzc48(mr[49:2]);
    // mr[48] is weight of leading one of x; sticky kept in mr[0]
    e  = 11'({3'd0, ex}) + 11'sd1 - 11'(lz);
    mr = mr << lz;
    return fp_round(sg, e, {mr[49:3], |mr[2:0]});
  endfunction

  // exact conversion of int8 or bf16 weight
  function automatic logic [31:0] weight_to_fp(input logic op, input logic [15:0] w);
    logic [7:0]  mag;
    logic [2:0]  p;
    logic [22:0] fr;
    if (op) return {w, 16'd0};
    if (w[7:0] == 8'd0) return FP_POS_ZERO;
    mag = w[7] ? 8'(-w[7:0]) : w[7:0];
    p = 3'd0;
    for (int i = 0; i < 8; i++) if (mag[i]) p = 3'(i);
    fr = {mag, 15'd0} << (5'd8 - {2'd0, p}) ;
    return {w[7], 8'(8'd127 + {5'd0, p}), fr};
  endfunction

endpackage

### src/mpdp_datapath.sv
module mpdp_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  mpdp_pkg::mpdp_cmd_t cmd,
  output mpdp_pkg::mpdp_sts_t sts,
  input  logic              in_op,
  input  logic [15:0]       in_weight_bits,
  input  logic [31:0]       in_activation,
  input  logic              in_last,
  input  logic [31:0]       in_row_scale,
  input  logic [31:0]       in_previous_output,
  input  logic [31:0]       beta,
  output logic [31:0]       result
);
  import mpdp_pkg::*;

  logic [31:0] w_r, act_r, scale_r, prev_r, prod_r, sum_r, acc_r;
  logic        op_r, last_r;

  assign sts.last    = last_r;
  assign sts.op      = op_r;
  assign sts.beta_nz = beta[30:0] != 31'd0;
  assign result      = is_nan(sum_r) ? FP_QNAN : sum_r;

  // request capture and one arithmetic step per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= FP_POS_ZERO;
    end else if (cmd.commit) begin
      acc_r <= last_r ? FP_POS_ZERO : (is_nan(sum_r) ? FP_QNAN : sum_r);
    end
    if (cmd.load) begin
      w_r     <= weight_to_fp(in_op, in_weight_bits);
      op_r    <= in_op;
      act_r   <= in_activation;
      last_r  <= in_last;
      scale_r <= in_row_scale;
      prev_r  <= in_previous_output;
    end
    if (cmd.mul_a) prod_r <= fp_mul(w_r, act_r);
    if (cmd.mul_b) prod_r <= fp_mul(beta, prev_r);
    if (cmd.add_a) sum_r  <= fp_add(acc_r, prod_r);
    if (cmd.mul_s) sum_r  <= fp_mul(sum_r, scale_r);
    if (cmd.add_b) sum_r  <= fp_add(sum_r, prod_r);
  end
endmodule

### src/mpdp_ctrl.sv
module mpdp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  mpdp_pkg::mpdp_sts_t sts,
  output mpdp_pkg::mpdp_cmd_t cmd
);
  import mpdp_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0, S_MA = 3'd1, S_AA = 3'd2, S_MS = 3'd3,
                         S_MB = 3'd4, S_AB = 3'd5, S_OUT = 3'd6;

  logic [2:0] state_r, state_nxt;

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = state_r == S_OUT;

  // sequencer
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) begin cmd.load = 1'b1; state_nxt = S_MA; end
      S_MA: begin cmd.mul_a = 1'b1; state_nxt = S_AA; end
      S_AA: begin
        cmd.add_a = 1'b1;
        state_nxt = S_IDLE;
        if (sts.last) state_nxt = !sts.op ? S_MS : (sts.beta_nz ? S_MB : S_OUT);
        else state_nxt = S_OUT;
      end
      S_MS: begin cmd.mul_s = 1'b1; state_nxt = sts.beta_nz ? S_MB : S_OUT; end
      S_MB: begin cmd.mul_b = 1'b1; state_nxt = S_AB; end
      S_AB: begin cmd.add_b = 1'b1; state_nxt = S_OUT; end
      S_OUT: begin
        // non-last items commit here without a result
        if (!sts.last) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end else if (!out_stall) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end
endmodule

### src/mixed_precision_dot_product_core.sv
// Mixed-precision dot-product core: each request brings an int8 or bf16
// weight and an fp32 activation; the product is added to an fp32 row sum, and
// on the row's last request one fp32 result is produced (scaled by row_scale
// for int8 rows, blended with previous_output through beta when beta is not
// zero). One request at a time; a last request also waits out any output stall.
// The sequencer steps one multiply or add per cycle, holding while the output
// is stalled. beta may be written only while idle.
module mixed_precision_dot_product_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [15:0] in_weight_bits,
  input  logic [31:0] in_activation,
  input  logic        in_last,
  input  logic [31:0] in_row_scale,
  input  logic [31:0] in_previous_output,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_result_value
);
  import mpdp_pkg::*;
  `include "mixed_precision_dot_product_core_assert.svh"

  logic [31:0] beta_r;
  mpdp_cmd_t   cmd;
  mpdp_sts_t   sts;
  logic        out_v;

  // blend factor register
  always_ff @(posedge clk) begin
    if (!rst_n)      beta_r <= FP_POS_ZERO;
    else if (cfg_we) beta_r <= cfg_wdata;
  end

  mpdp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_v), .out_stall(out_stall), .sts(sts), .cmd(cmd)
  );

  mpdp_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .in_op(in_op),
    .in_weight_bits(in_weight_bits), .in_activation(in_activation),
    .in_last(in_last), .in_row_scale(in_row_scale),
    .in_previous_output(in_previous_output), .beta(beta_r),
    .result(out_result_value)
  );

  assign out_valid = out_v & sts.last;

  `MPDP_ASSERT_IMPL(a_no_accept_busy, out_valid |-> in_stall, "accept while result pending")
  `MPDP_ASSERT_IMPL(a_load_idle, cmd.load |-> !in_stall, "load while busy")
  `MPDP_ASSERT_RST(a_rst_idle, !rst_n |=> !out_valid, "result after reset")
endmodule
